### rtl/tccs_pkg.sv
// Package: console geometry, command codes and result types for the cursor and scroll manager.
package tccs_pkg;

  localparam int unsigned COLUMNS   = 240;
  localparam int unsigned ROWS      = 67;
  localparam int unsigned TAB_STEP  = 3;
  localparam int unsigned QDEPTH    = 2;
  localparam logic [31:0] FG_COLOUR = 32'hFFFF_FFFF;
  localparam logic [6:0]  ROW_SAT   = 7'd127;
  localparam logic [8:0]  COL_SAT   = 9'd511;
  localparam logic [8:0]  SETCOL_SAT = 9'd255;

  typedef enum logic [2:0] {
    OP_PUTC   = 3'd0,
    OP_NL     = 3'd1,
    OP_TAB    = 3'd2,
    OP_COLOUR = 3'd3,
    OP_SETCOL = 3'd4
  } op_e;

  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [6:0]  row;
    logic [7:0]  column;
    logic [7:0]  char_code;
    logic [31:0] colour;
  } res_t;

  // up to three results produced by one command
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      res;
  } job_t;

  function automatic logic [6:0] row_inc(input logic [6:0] r);
    return (r == ROW_SAT) ? ROW_SAT : r + 7'd1;
  endfunction

  function automatic logic [6:0] top_adv(input logic [6:0] t);
    logic [7:0] s;
    s = {1'b0, t} + 8'd1;
    return (s >= 8'(ROWS)) ? 7'd0 : s[6:0];
  endfunction

  function automatic res_t mk_res(input logic kind, input logic [6:0] row,
                                  input logic [7:0] column, input logic [7:0] ch,
                                  input logic [31:0] colour);
    res_t r;
    r.kind      = kind;
    r.row       = row;
    r.column    = column;
    r.char_code = ch;
    r.colour    = colour;
    return r;
  endfunction

endpackage

### rtl/tccs_if.sv
// Interfaces: command channel and result channel, valid/ready with payload.
interface tccs_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [7:0]  char_code;
  logic [31:0] value;

  modport source (output valid, output op, output char_code, output value, input ready);
  modport sink   (input valid, input op, input char_code, input value, output ready);
endinterface

interface tccs_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [6:0]  row;
  logic [7:0]  column;
  logic [7:0]  char_code_out;
  logic [31:0] colour_out;
  logic        last;

  modport source (output valid, output kind, output row, output column,
                  output char_code_out, output colour_out, output last, input ready);
  modport sink   (input valid, input kind, input row, input column,
                  input char_code_out, input colour_out, input last, output ready);
endinterface

### rtl/text_console_cursor_scroll.sv
// Top level: text console cursor and scroll manager.
//
//  channel | dir | beat payload
//  cmd_i   | in  | op, char_code, value
//  res_o   | out | kind, row, column, char_code_out, colour_out, last
//
// A command is taken whenever the two-entry job queue has room;
// its state update is done in that cycle. The back end drains one result beat
// per cycle while the result channel is ready; a command yields up to three
// beats, for a character that wraps and hits the bottom. The first result beat
// of a command passes through the job queue and then the output register.
// Reset clears cursor, top row and scroll flag and sets the foreground colour.
// A stalled result holds in the output register; the queue absorbs commands.
module text_console_cursor_scroll (
  input  logic        clk_i,
  input  logic        rst_ni,
  tccs_cmd_if.sink    cmd_i,
  tccs_res_if.source  res_o
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_empty;
  tccs_pkg::job_t    job;
  tccs_pkg::job_t    head;

  tccs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .push_o   (push),
    .job_o    (job)
  );

  tccs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  tccs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .head_i  (head),
    .pop_o   (pop),
    .res_o   (res_o)
  );

`ifndef SYNTHESIS
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.row < 7'(tccs_pkg::ROWS)))
    else $error("result row out of range");

  a_clear_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == tccs_pkg::KIND_CLEAR)
      |-> (res_o.column == 8'd0 && res_o.char_code_out == 8'd0))
    else $error("row clear with nonzero column or char");

  a_cell_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == tccs_pkg::KIND_CELL)
      |-> (res_o.column < 8'(tccs_pkg::COLUMNS) && res_o.last))
    else $error("cell write off screen or not final beat");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty job queue");
`endif

endmodule

### rtl/tccs_front.sv
// Front end: takes commands, updates cursor/scroll state, builds the job of results.
module tccs_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tccs_cmd_if.sink          cmd_i,
  input  logic              q_full_i,
  output logic              push_o,
  output tccs_pkg::job_t    job_o
);

  logic [8:0]  col_q, col_d;
  logic [6:0]  row_q, row_d;
  logic [6:0]  top_q, top_d;
  logic        scr_q, scr_d;
  logic [31:0] colour_q, colour_d;
  logic [6:0]  line;
  logic [1:0]  n;
  logic [9:0]  tab_sum;
  logic        accept;

  assign cmd_i.ready = !q_full_i;
  assign accept      = cmd_i.valid && !q_full_i;

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    top_d    = top_q;
    scr_d    = scr_q;
    colour_d = colour_q;
    job_o    = '0;
    n        = 2'd0;
    line     = 7'd0;
    tab_sum  = {1'b0, col_q} + 10'(tccs_pkg::TAB_STEP);
    unique case (tccs_pkg::op_e'(cmd_i.op))
      tccs_pkg::OP_PUTC: begin
        if (col_q >= 9'(tccs_pkg::COLUMNS)) begin
          row_d = tccs_pkg::row_inc(row_q);
          col_d = 9'd0;
          if (scr_q) begin
            top_d = tccs_pkg::top_adv(top_q);
            job_o.res[n] = tccs_pkg::mk_res(tccs_pkg::KIND_CLEAR, top_d, 8'd0, 8'd0,
                                            colour_q);
            n = n + 2'd1;
          end
        end
        // bottom reached: start or keep scrolling and clear the new top row
        if (row_d >= 7'(tccs_pkg::ROWS)) begin
          if (!scr_q) begin
            top_d = 7'd0;
            scr_d = 1'b1;
          end
          row_d = 7'(tccs_pkg::ROWS - 1);
          job_o.res[n] = tccs_pkg::mk_res(tccs_pkg::KIND_CLEAR, top_d, 8'd0, 8'd0,
                                          colour_q);
          n = n + 2'd1;
        end
        if (scr_d) begin
          line = (top_d == 7'd0) ? 7'(tccs_pkg::ROWS - 1) : top_d - 7'd1;
        end else begin
          line = row_d;
        end
        job_o.res[n] = tccs_pkg::mk_res(tccs_pkg::KIND_CELL, line, col_d[7:0],
                                        cmd_i.char_code, colour_q);
        n = n + 2'd1;
        col_d = col_d + 9'd1;
      end
      tccs_pkg::OP_NL: begin
        if (scr_q) begin
          job_o.res[n] = tccs_pkg::mk_res(tccs_pkg::KIND_CLEAR, top_q, 8'd0, 8'd0,
                                          colour_q);
          n = n + 2'd1;
          top_d = tccs_pkg::top_adv(top_q);
        end
        col_d = 9'd0;
        row_d = tccs_pkg::row_inc(row_q);
      end
      tccs_pkg::OP_TAB: begin
        col_d = (tab_sum > {1'b0, tccs_pkg::COL_SAT}) ? tccs_pkg::COL_SAT : tab_sum[8:0];
      end
      tccs_pkg::OP_COLOUR: begin
        colour_d = cmd_i.value;
      end
      tccs_pkg::OP_SETCOL: begin
        col_d = (cmd_i.value > 32'd255) ? tccs_pkg::SETCOL_SAT : cmd_i.value[8:0];
      end
      default: begin
      end
    endcase
    job_o.cnt = n;
  end

  assign push_o = accept && (n != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      top_q    <= '0;
      scr_q    <= 1'b0;
      colour_q <= tccs_pkg::FG_COLOUR;
    end else if (accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      top_q    <= top_d;
      scr_q    <= scr_d;
      colour_q <= colour_d;
    end
  end

endmodule

### rtl/tccs_queue.sv
// Job queue: two-entry register FIFO between front end and back end.
module tccs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tccs_pkg::job_t    job_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output tccs_pkg::job_t    head_o
);

  localparam int unsigned PW = $clog2(tccs_pkg::QDEPTH);

  tccs_pkg::job_t    mem_q [tccs_pkg::QDEPTH];
  logic [PW-1:0]     wp_q, rp_q;
  logic [PW:0]       cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(tccs_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + PW'(1);
      if (pop_i)  rp_q <= rp_q + PW'(1);
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

### rtl/tccs_back.sv
// Back end: unrolls each job into result beats through an output register.
module tccs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  tccs_pkg::job_t    head_i,
  output logic              pop_o,
  tccs_res_if.source        res_o
);

  logic [1:0]        idx_q;
  logic              load;
  logic              is_last;
  logic              out_valid_q;
  tccs_pkg::res_t    out_q;
  logic              out_last_q;

  assign load    = !empty_i && (!out_valid_q || res_o.ready);
  assign is_last = (idx_q == head_i.cnt - 2'd1);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q      <= head_i.res[idx_q];
      out_last_q <= is_last;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.kind          = out_q.kind;
  assign res_o.row           = out_q.row;
  assign res_o.column        = out_q.column;
  assign res_o.char_code_out = out_q.char_code;
  assign res_o.colour_out    = out_q.colour;
  assign res_o.last          = out_last_q;

endmodule
